/* rtl/assert_macros.svh */
// assertion helpers used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property holds on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/pctt_pkg.sv */
// ----------------------------------------------------------------------------
// pctt_pkg
// Shared codes and types for the pending command timeout table.
// ----------------------------------------------------------------------------
package pctt_pkg;

  localparam int unsigned SlotNumW = 4;
  localparam int unsigned UidOutW  = 16;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_DEL_UID = 3'd2,
    ACT_DEL_CODE = 3'd3,
    ACT_REPLY   = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    EV_ADDED      = 4'd0,
    EV_REPLACED   = 4'd1,
    EV_NONE_DEL   = 4'd2,
    EV_DELETED    = 4'd3,
    EV_TIMED_OUT  = 4'd4,
    EV_TICK_DONE  = 4'd5,
    EV_REPLY_ENT  = 4'd6,
    EV_REPLY_DEF  = 4'd7,
    EV_REPLY_DROP = 4'd8
  } event_t;

  typedef enum logic [2:0] {
    CLS_SUCCESS     = 3'd0,
    CLS_FAIL        = 3'd1,
    CLS_PROGRESS    = 3'd2,
    CLS_UNSUPPORTED = 3'd3,
    CLS_OTHER       = 3'd4
  } class_t;

  typedef enum logic [2:0] {
    REG_SUCCESS     = 3'd0,
    REG_FAIL        = 3'd1,
    REG_PROGRESS    = 3'd2,
    REG_UNSUPPORTED = 3'd3,
    REG_DEFAULT     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] code_success;
    logic [7:0] code_fail;
    logic [7:0] code_progress;
    logic [7:0] code_unsupported;
    logic       default_present;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         event_res;
    logic [2:0]         reply_class;
    logic [SlotNumW-1:0] slot;
    logic [UidOutW-1:0] event_uid;
    logic [7:0]         event_handler;
    logic               entry_removed;
    logic               last;
  } result_t;

  function automatic class_t classify(input logic [7:0] code, input cfg_t c);
    class_t r;
    if (code == c.code_success) r = CLS_SUCCESS;
    else if (code == c.code_fail) r = CLS_FAIL;
    else if (code == c.code_progress) r = CLS_PROGRESS;
    else if (code == c.code_unsupported) r = CLS_UNSUPPORTED;
    else r = CLS_OTHER;
    return r;
  endfunction

endpackage

/* rtl/pctt_regs.sv */
// ----------------------------------------------------------------------------
// pctt_regs
// APB-style register file holding the reply codes and default handler flag.
// ----------------------------------------------------------------------------
module pctt_regs
  import pctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_success     <= 8'd0;
      cfg_r.code_fail        <= 8'd1;
      cfg_r.code_progress    <= 8'd2;
      cfg_r.code_unsupported <= 8'd3;
      cfg_r.default_present  <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_SUCCESS:     cfg_r.code_success     <= pwdata[7:0];
        REG_FAIL:        cfg_r.code_fail        <= pwdata[7:0];
        REG_PROGRESS:    cfg_r.code_progress    <= pwdata[7:0];
        REG_UNSUPPORTED: cfg_r.code_unsupported <= pwdata[7:0];
        REG_DEFAULT:     cfg_r.default_present  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_SUCCESS:     prdata = {24'd0, cfg_r.code_success};
        REG_FAIL:        prdata = {24'd0, cfg_r.code_fail};
        REG_PROGRESS:    prdata = {24'd0, cfg_r.code_progress};
        REG_UNSUPPORTED: prdata = {24'd0, cfg_r.code_unsupported};
        REG_DEFAULT:     prdata = {31'd0, cfg_r.default_present};
        default:         prdata = 32'd0;
      endcase
    end
  end

endmodule

/* rtl/pending_command_timeout_table_core.sv */
// ----------------------------------------------------------------------------
// pending_command_timeout_table_core
// Outstanding command table with timeout expiry, scanned one slot a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel  | handshake             | payload
// in_      | in_valid / in_ready   | action, tick count, uid, code, timeout, tag
// out_     | out_valid / out_ready | event, class, slot, uid, handler, flags
// cfg_     | psel penable pwrite   | reply codes, default handler flag
//
// an item goes through the accept, a read pass over the slot memory (one slot
// a cycle while the output is not stalled, registered read), a write-back
// and an emit step before the next accept
// add stops its pass at the first free slot
// valid flags sit in flip-flops cleared at reset; the entry memory needs no
// clearing pass
// a full output register holds the scan until out_ready takes the beat; a new
// item is accepted while the final beat of the previous one still waits
// ----------------------------------------------------------------------------
module pending_command_timeout_table_core
  import pctt_pkg::*;
#(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned UID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_tick_count,
  input  logic [15:0] in_cmd_id,
  input  logic [7:0]  in_message_code,
  input  logic [31:0] in_timeout_ticks,
  input  logic [7:0]  in_handler_tag,
  input  logic        in_reply_terminal,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [2:0]  out_reply_class,
  output logic [3:0]  out_slot,
  output logic [15:0] out_event_uid,
  output logic [7:0]  out_event_handler,
  output logic        out_entry_removed,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "assert_macros.svh"

  localparam int unsigned IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned UW  = (UID_BITS < 16) ? UID_BITS : 16;
  localparam int unsigned EW  = UW + 8 + 8 + 64 + 32;

  cfg_t cfg;

  pctt_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  // entry memory: uid, code, handler, deadline, timeout
  typedef struct packed {
    logic [UW-1:0] uid;
    logic [7:0]    code;
    logic [7:0]    handler;
    logic [63:0]   deadline;
    logic [31:0]   timeout;
  } entry_t;

  entry_t mem [SLOTS];
  entry_t rd_q;
  logic   mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  logic [SLOTS-1:0] valid_r;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_WB, S_EMIT} state_t;
  state_t state_r;

  // latched item
  logic [2:0]   act_r;
  logic [UW-1:0] uid_r;
  logic [7:0]   code_r, tag_r;
  logic [31:0]  to_r;
  logic         term_r;
  logic [63:0]  now_r;

  logic [CW-1:0] cnt_r;     // slot being issued / arrived
  logic          rdv_r;     // read data valid
  logic [IW-1:0] rdi_r;     // slot of read data

  logic          any_r;
  logic [IW-1:0] sel_r;     // chosen slot
  logic [UW-1:0] suid_r;
  logic [7:0]    shnd_r;
  logic          free_r;
  logic [UW-1:0] min_r;
  entry_t        sent_r;    // entry of the reply match
  logic [SLOTS-1:0] clr_r;  // slots to clear on the write-back

  result_t res_r;
  logic    ov_r;

  logic uid_hit, code_hit;
  assign uid_hit  = rd_q.uid == uid_r;
  assign code_hit = rd_q.code == code_r;

  class_t cls;
  assign cls = classify(code_r, cfg);

  assign in_ready = (state_r == S_IDLE);

  assign out_valid         = ov_r;
  assign out_event_res     = res_r.event_res;
  assign out_reply_class   = res_r.reply_class;
  assign out_slot          = res_r.slot;
  assign out_event_uid     = res_r.event_uid;
  assign out_event_handler = res_r.event_handler;
  assign out_entry_removed = res_r.entry_removed;
  assign out_last          = res_r.last;

  logic [SlotNumW-1:0] rdi_s, sel_s;
  assign rdi_s = SlotNumW'({{(32-IW){1'b0}}, rdi_r});
  assign sel_s = SlotNumW'({{(32-IW){1'b0}}, sel_r});

  logic [15:0] suid16, ruid16;
  assign suid16 = 16'({{(64-UW){1'b0}}, suid_r});
  assign ruid16 = 16'({{(64-UW){1'b0}}, uid_r});

  logic stall;
  assign stall = ov_r && !out_ready;

  logic [IW-1:0] cnt_i;
  assign cnt_i = cnt_r[IW-1:0];

  logic scanning, add_free, to_hit, to_set, emit_go;
  assign scanning = (state_r == S_SCAN) || (state_r == S_LAST);
  assign add_free = rdv_r && act_r == ACT_ADD && !free_r && !valid_r[rdi_r];
  assign to_hit   = rdv_r && act_r == ACT_TICK && valid_r[rdi_r] && rd_q.deadline <= now_r;
  assign to_set   = scanning && !stall && to_hit;
  assign emit_go  = (state_r == S_EMIT) && !stall;

  always_comb begin
    // re-read the waiting slot while the output is stalled
    mem_ra = (stall && rdv_r) ? rdi_r : cnt_i;
    mem_we = 1'b0;
    mem_wa = sel_r;
    mem_wd = sent_r;
    if (state_r == S_WB) begin
      if (act_r == ACT_ADD) begin
        mem_we = 1'b1;
        mem_wd.uid = uid_r;
        mem_wd.code = code_r;
        mem_wd.handler = tag_r;
        mem_wd.timeout = to_r;
        mem_wd.deadline = {32'd0, to_r} + now_r;
      end else if (act_r == ACT_REPLY && any_r && !term_r &&
                   (cls == CLS_PROGRESS || cls == CLS_OTHER)) begin
        mem_we = 1'b1;
        mem_wd.deadline = {32'd0, sent_r.timeout} + now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ov_r    <= 1'b0;
      rdv_r   <= 1'b0;
      now_r   <= 64'd0;
      cnt_r   <= '0;
    end else begin
      if (to_set || emit_go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            act_r  <= in_action;
            uid_r  <= in_cmd_id[UW-1:0];
            code_r <= in_message_code;
            tag_r  <= in_handler_tag;
            to_r   <= in_timeout_ticks;
            term_r <= in_reply_terminal;
            if (in_action == ACT_TICK) now_r <= now_r + {32'd0, in_tick_count};
            any_r  <= 1'b0;
            free_r <= 1'b0;
            sel_r  <= '0;
            suid_r <= '0;
            shnd_r <= '0;
            min_r  <= '1;
            clr_r  <= '0;
            cnt_r  <= '0;
            rdv_r  <= 1'b0;
            if (in_action <= ACT_REPLY) state_r <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          if (!stall) begin
            if (state_r == S_SCAN) rdi_r <= cnt_i;
            if (state_r == S_SCAN && cnt_r != CW'(SLOTS - 1)) cnt_r <= cnt_r + 1'b1;
            rdv_r <= (state_r == S_SCAN) && !add_free;
            if (add_free || (state_r == S_LAST && !rdv_r)) state_r <= S_WB;
            else if (state_r == S_SCAN && cnt_r == CW'(SLOTS - 1)) state_r <= S_LAST;
            if (rdv_r) begin
              unique case (act_r)
                ACT_TICK: begin
                  if (to_hit) begin
                    valid_r[rdi_r] <= 1'b0;
                    res_r <= '{EV_TIMED_OUT, CLS_SUCCESS, rdi_s, 16'({{(64-UW){1'b0}}, rd_q.uid}),
                               rd_q.handler, 1'b0, 1'b0};
                  end
                end
                ACT_ADD: begin
                  if (add_free) begin
                    free_r <= 1'b1;
                    sel_r  <= rdi_r;
                  end else if (!free_r) begin
                    if (rd_q.uid < min_r) begin
                      min_r  <= rd_q.uid;
                      sel_r  <= rdi_r;
                      suid_r <= rd_q.uid;
                      shnd_r <= rd_q.handler;
                    end else if (rdi_r == '0) begin
                      suid_r <= rd_q.uid;
                      shnd_r <= rd_q.handler;
                    end
                  end
                end
                ACT_DEL_UID, ACT_DEL_CODE: begin
                  if (valid_r[rdi_r] && ((act_r == ACT_DEL_UID) ? uid_hit : code_hit)) begin
                    valid_r[rdi_r] <= 1'b0;
                    if (!any_r) begin
                      sel_r <= rdi_r; suid_r <= rd_q.uid; shnd_r <= rd_q.handler;
                    end
                    any_r <= 1'b1;
                  end
                end
                ACT_REPLY: begin
                  if (valid_r[rdi_r] && uid_hit) begin
                    any_r  <= 1'b1;
                    sel_r  <= rdi_r;
                    sent_r <= rd_q;
                    clr_r[rdi_r] <= 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_WB: begin
          if (act_r == ACT_ADD) valid_r[sel_r] <= 1'b1;
          if (act_r == ACT_REPLY && any_r) begin
            if (cls == CLS_PROGRESS || cls == CLS_OTHER) begin
              if (term_r) valid_r <= valid_r & ~clr_r;
              else clr_r <= '0;
            end else begin
              valid_r <= valid_r & ~clr_r;
            end
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!stall) begin
            state_r <= S_IDLE;
            unique case (act_r)
              ACT_TICK: res_r <= '{EV_TICK_DONE, CLS_SUCCESS, '0, '0, '0, 1'b0, 1'b1};
              ACT_ADD: begin
                if (free_r) res_r <= '{EV_ADDED, CLS_SUCCESS, sel_s, ruid16, tag_r, 1'b0, 1'b1};
                else res_r <= '{EV_REPLACED, CLS_SUCCESS, sel_s, suid16, shnd_r, 1'b0, 1'b1};
              end
              ACT_DEL_UID, ACT_DEL_CODE: begin
                if (any_r) res_r <= '{EV_DELETED, CLS_SUCCESS, sel_s, suid16, shnd_r, 1'b0, 1'b1};
                else res_r <= '{EV_NONE_DEL, CLS_SUCCESS, '0, '0, '0, 1'b0, 1'b1};
              end
              default: begin
                if (any_r) res_r <= '{EV_REPLY_ENT, cls, sel_s, ruid16, sent_r.handler,
                                      clr_r != '0, 1'b1};
                else res_r <= '{cfg.default_present ? EV_REPLY_DEF : EV_REPLY_DROP, cls,
                                '0, ruid16, '0, 1'b0, 1'b1};
              end
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a replaced entry keeps the add path: fill sel_r when the table is full
  `ASSERT_CLK(a_ready_idle, clk, rst_n, in_ready |-> state_r == S_IDLE, "ready outside idle")
  `ASSERT_CLK(a_hold_out, clk, rst_n, (ov_r && !out_ready) |=> ov_r, "result dropped")
  `ASSERT_CLK(a_add_sets, clk, rst_n,
    (state_r == S_WB && act_r == ACT_ADD) |=> valid_r[$past(sel_r)], "add left slot empty")

endmodule
